// File: hdl/c3er_pkg.sv
// shared constants, types and helpers of the 3x3 replicate-border convolution core
`timescale 1ns / 1ps
package c3er_pkg;

    // geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COEF_BITS  = 16;
    localparam int FRAC_BITS  = COEF_BITS - 2;

    // fixed field widths
    localparam int PIX_BITS       = 8;
    localparam int DIM_BITS       = 11;
    localparam int COEF_REG_BITS  = 48;
    localparam int CFG_INDEX_BITS = 3;

    // derived widths
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_BITS    = DIM_BITS + 2;
    localparam int LINE_BITS   = 2 * PIX_BITS;
    localparam int WIN_DIM     = 3;
    localparam int PROD_BITS   = PIX_BITS + 1 + COEF_BITS;
    localparam int ROWSUM_BITS = PROD_BITS + 2;
    localparam int TOTAL_BITS  = PROD_BITS + 4;
    localparam int SAT_BITS    = TOTAL_BITS - FRAC_BITS;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // rounding and saturation
    localparam logic [TOTAL_BITS-1:0] ROUND_HALF = TOTAL_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [PIX_BITS-1:0]   PIX_MAX    = PIX_BITS'((1 << PIX_BITS) - 1);

    // input operation codes
    localparam logic OP_FLUSH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_TOP     = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_MIDDLE  = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_BOTTOM  = CFG_INDEX_BITS'(4);

    // register reset values
    localparam logic [DIM_BITS-1:0]      FRAME_WIDTH_RST  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0]      FRAME_HEIGHT_RST = DIM_BITS'(1024);
    localparam logic [COEF_REG_BITS-1:0] COEF_EDGE_RST    = '0;
    localparam logic [COEF_REG_BITS-1:0] COEF_MIDDLE_RST  = COEF_REG_BITS'(64'h4000_0000);

    // one classified word from the front end
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [PIX_BITS-1:0] pixel;
        logic                store_only;
        logic                take;
        logic                top_is_mid;
        logic                bot_is_mid;
        logic                rep_shift;
        logic                emit;
        logic                first_col;
        logic                eof;
    } t_cmd;

    // window, [row][col], row 0 on top, col 0 on the left
    typedef logic [WIN_DIM-1:0][WIN_DIM-1:0][PIX_BITS-1:0] t_win;

    // coefficient rows, row 0 on top
    typedef logic [WIN_DIM-1:0][COEF_REG_BITS-1:0] t_coef_rows;

    // zero acts as one, above the limit acts as the limit
    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v,
                                                   input logic [DIM_BITS-1:0] maxv);
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: hdl/c3er_front.sv
// front end: raster counters and classification of incoming words
`timescale 1ns / 1ps
module c3er_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [c3er_pkg::DIM_BITS-1:0] i_width,
    input  logic [c3er_pkg::DIM_BITS-1:0] i_height,
    input  logic                          i_in_valid,
    input  logic                          i_op,
    input  logic [c3er_pkg::PIX_BITS-1:0] i_pixel_in,
    input  logic                          i_full,
    output logic                          o_in_stall,
    output logic                          o_push,
    output c3er_pkg::t_cmd                o_cmd
);

    logic [c3er_pkg::COL_BITS-1:0] r_col;
    logic [c3er_pkg::ROW_BITS-1:0] r_row;
    logic [c3er_pkg::COL_BITS-1:0] n_col;
    logic [c3er_pkg::ROW_BITS-1:0] n_row;

    logic [c3er_pkg::CMP_BITS-1:0] w_row_x;
    logic [c3er_pkg::CMP_BITS-1:0] w_h_x;
    logic [c3er_pkg::CMP_BITS-1:0] w_col_inc;
    logic                          w_drain;
    logic                          w_past_end;
    logic                          w_col0;
    logic                          w_row0;
    logic                          w_ignore;
    logic                          w_accept;

    always_comb begin
        w_row_x    = c3er_pkg::CMP_BITS'(r_row);
        w_h_x      = c3er_pkg::CMP_BITS'(i_height);
        w_col_inc  = c3er_pkg::CMP_BITS'(r_col) + c3er_pkg::CMP_BITS'(1);
        w_drain    = w_row_x >= w_h_x;
        w_past_end = w_row_x > w_h_x;
        w_col0     = (r_col == '0);
        w_row0     = (r_row == '0);
        // flush while pixels are still expected does nothing
        w_ignore   = !w_drain && (i_op == c3er_pkg::OP_FLUSH);
        o_in_stall = i_full;
        w_accept   = i_in_valid && !i_full;
        o_push     = w_accept && !w_ignore;

        o_cmd.col        = r_col;
        o_cmd.pixel      = i_pixel_in;
        o_cmd.store_only = w_row0;
        o_cmd.take       = !w_row0 && !w_past_end;
        o_cmd.top_is_mid = (r_row == c3er_pkg::ROW_BITS'(1));
        o_cmd.bot_is_mid = w_drain;
        o_cmd.rep_shift  = w_col0 && (w_row_x >= c3er_pkg::CMP_BITS'(2));
        o_cmd.emit       = w_col0 ? (w_row_x >= c3er_pkg::CMP_BITS'(2)) : !w_row0;
        o_cmd.first_col  = (r_col == c3er_pkg::COL_BITS'(1))
                           || (w_col0 && (i_width == c3er_pkg::DIM_BITS'(1)));
        o_cmd.eof        = w_col0 && w_past_end;

        // next raster position
        if (w_past_end) begin
            n_col = '0;
            n_row = '0;
        end else if (w_col_inc >= c3er_pkg::CMP_BITS'(i_width)) begin
            n_col = '0;
            n_row = r_row + c3er_pkg::ROW_BITS'(1);
        end else begin
            n_col = w_col_inc[c3er_pkg::COL_BITS-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // column stays inside the row, row at most one past the last drain row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c3er_pkg::CMP_BITS'(r_col) < c3er_pkg::CMP_BITS'(i_width))
        else $error("input column beyond frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_x <= w_h_x + c3er_pkg::CMP_BITS'(1))
        else $error("input row beyond drain row");

endmodule

// File: hdl/c3er_fifo.sv
// short command queue between front end and back end
`timescale 1ns / 1ps
module c3er_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  c3er_pkg::t_cmd                 i_cmd,
    input  logic                           i_pop,
    output c3er_pkg::t_cmd                 o_head,
    output logic                           o_empty,
    output logic                           o_full,
    output logic [c3er_pkg::QCNT_BITS-1:0] o_count
);

    c3er_pkg::t_cmd                 r_mem [c3er_pkg::QUEUE_DEPTH];
    logic [c3er_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [c3er_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [c3er_pkg::QCNT_BITS-1:0] r_count;
    logic [c3er_pkg::QCNT_BITS-1:0] n_count;

    always_comb begin
        o_head  = r_mem[r_rd_ptr];
        o_empty = (r_count == '0);
        o_full  = (r_count == c3er_pkg::QCNT_BITS'(c3er_pkg::QUEUE_DEPTH));
        o_count = r_count;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + c3er_pkg::QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - c3er_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + c3er_pkg::QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + c3er_pkg::QPTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    // fill level never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= c3er_pkg::QCNT_BITS'(c3er_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

endmodule

// File: hdl/c3er_window.sv
// line stores and 3x3 window, with edge replication
`timescale 1ns / 1ps
module c3er_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_clear,
    input  logic           i_cmd_valid,
    input  c3er_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output c3er_pkg::t_win o_pix,
    output logic           o_eof
);

    // one word per column: two rows above in the high byte, row above in the low byte
    logic [c3er_pkg::LINE_BITS-1:0] r_line [c3er_pkg::MAX_WIDTH];
    logic [c3er_pkg::LINE_BITS-1:0] r_rd;
    logic                           r_fwd_hit;
    logic [c3er_pkg::LINE_BITS-1:0] r_fwd_data;

    logic                           r_s1_valid;
    c3er_pkg::t_cmd                 r_s1_cmd;
    c3er_pkg::t_win                 r_win;
    logic                           r_s2_valid;
    c3er_pkg::t_win                 r_s2_pix;
    logic                           r_s2_eof;

    logic [c3er_pkg::LINE_BITS-1:0] w_rd;
    logic [c3er_pkg::PIX_BITS-1:0]  w_above;
    logic [c3er_pkg::PIX_BITS-1:0]  w_two;
    logic [c3er_pkg::WIN_DIM-1:0][c3er_pkg::PIX_BITS-1:0] w_new_col;
    c3er_pkg::t_win                 w_base;
    c3er_pkg::t_win                 w_after;
    c3er_pkg::t_win                 w_emit;
    logic                           w_wr_en;
    logic [c3er_pkg::COL_BITS-1:0]  w_wr_addr;
    logic [c3er_pkg::LINE_BITS-1:0] w_wr_data;

    always_comb begin
        // a write to the same column at the read edge has not reached the read data
        w_rd    = r_fwd_hit ? r_fwd_data : r_rd;
        w_above = w_rd[c3er_pkg::PIX_BITS-1:0];
        w_two   = w_rd[c3er_pkg::LINE_BITS-1:c3er_pkg::PIX_BITS];

        w_new_col[0] = r_s1_cmd.top_is_mid ? w_above : w_two;
        w_new_col[1] = w_above;
        w_new_col[2] = r_s1_cmd.bot_is_mid ? w_above : r_s1_cmd.pixel;

        for (int rr = 0; rr < c3er_pkg::WIN_DIM; rr++) begin
            // right edge: shift left and repeat the last column
            if (r_s1_cmd.rep_shift) begin
                w_base[rr][0] = r_win[rr][1];
                w_base[rr][1] = r_win[rr][2];
                w_base[rr][2] = r_win[rr][2];
            end else begin
                w_base[rr] = r_win[rr];
            end
            if (r_s1_cmd.take) begin
                w_after[rr][0] = w_base[rr][1];
                w_after[rr][1] = w_base[rr][2];
                w_after[rr][2] = w_new_col[rr];
            end else begin
                w_after[rr] = w_base[rr];
            end
            w_emit[rr] = r_s1_cmd.rep_shift ? w_base[rr] : w_after[rr];
            // left edge
            if (r_s1_cmd.first_col) begin
                w_emit[rr][0] = w_emit[rr][1];
            end
        end

        w_wr_en   = i_adv && r_s1_valid && (r_s1_cmd.store_only || r_s1_cmd.take);
        w_wr_addr = r_s1_cmd.col;
        w_wr_data = r_s1_cmd.store_only ? {r_s1_cmd.pixel, r_s1_cmd.pixel}
                                        : {w_above, w_new_col[2]};

        o_valid = r_s2_valid;
        o_pix   = r_s2_pix;
        o_eof   = r_s2_eof;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_line[w_wr_addr] <= w_wr_data;
        end
        if (i_adv) begin
            r_rd <= r_line[i_cmd.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_cmd   <= i_cmd;
            r_fwd_hit  <= w_wr_en && (w_wr_addr == i_cmd.col);
            r_fwd_data <= w_wr_data;
            r_s2_pix   <= w_emit;
            r_s2_eof   <= r_s1_cmd.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_cmd_valid;
            r_s2_valid <= r_s1_valid && r_s1_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_clear) begin
            r_win <= '0;
        end else if (i_adv && r_s1_valid) begin
            r_win <= w_after;
        end
    end

    // an end-of-frame word is always one that yields a pixel
    a_eof_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_cmd.eof) |-> (r_s1_cmd.emit && r_s1_cmd.rep_shift))
        else $error("end of frame on a word without output");

endmodule

// File: hdl/c3er_mac.sv
// nine products, adder tree, rounding, saturation and output register
`timescale 1ns / 1ps
module c3er_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  c3er_pkg::t_win                i_pix,
    input  logic                          i_eof,
    input  c3er_pkg::t_coef_rows          i_coef,
    output logic                          o_valid,
    output logic [c3er_pkg::PIX_BITS-1:0] o_pixel_out,
    output logic                          o_eof
);

    logic signed [c3er_pkg::PROD_BITS-1:0]   r_prod [c3er_pkg::WIN_DIM][c3er_pkg::WIN_DIM];
    logic signed [c3er_pkg::ROWSUM_BITS-1:0] r_row_sum [c3er_pkg::WIN_DIM];
    logic signed [c3er_pkg::TOTAL_BITS-1:0]  r_total;
    logic                                    r_s3_valid;
    logic                                    r_s4_valid;
    logic                                    r_s5_valid;
    logic                                    r_s3_eof;
    logic                                    r_s4_eof;
    logic                                    r_s5_eof;
    logic                                    r_out_valid;
    logic [c3er_pkg::PIX_BITS-1:0]           r_out_pixel;
    logic                                    r_out_eof;

    logic                                    w_pos;
    logic [c3er_pkg::TOTAL_BITS-1:0]         w_rounded;
    logic [c3er_pkg::SAT_BITS-1:0]           w_shifted;
    logic [c3er_pkg::PIX_BITS-1:0]           w_pix;

    always_comb begin
        w_pos     = !r_total[c3er_pkg::TOTAL_BITS-1] && (r_total != '0);
        w_rounded = $unsigned(r_total) + c3er_pkg::ROUND_HALF;
        w_shifted = w_rounded[c3er_pkg::TOTAL_BITS-1:c3er_pkg::FRAC_BITS];
        if (!w_pos) begin
            w_pix = '0;
        end else if (w_shifted > c3er_pkg::SAT_BITS'(c3er_pkg::PIX_MAX)) begin
            w_pix = c3er_pkg::PIX_MAX;
        end else begin
            w_pix = w_shifted[c3er_pkg::PIX_BITS-1:0];
        end
        o_valid     = r_out_valid;
        o_pixel_out = r_out_pixel;
        o_eof       = r_out_eof;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int rr = 0; rr < c3er_pkg::WIN_DIM; rr++) begin
                for (int kk = 0; kk < c3er_pkg::WIN_DIM; kk++) begin
                    r_prod[rr][kk] <= $signed({1'b0, i_pix[rr][kk]})
                        * $signed(i_coef[rr][kk*c3er_pkg::COEF_BITS +: c3er_pkg::COEF_BITS]);
                end
                r_row_sum[rr] <= c3er_pkg::ROWSUM_BITS'(r_prod[rr][0])
                               + c3er_pkg::ROWSUM_BITS'(r_prod[rr][1])
                               + c3er_pkg::ROWSUM_BITS'(r_prod[rr][2]);
            end
            r_total     <= c3er_pkg::TOTAL_BITS'(r_row_sum[0])
                         + c3er_pkg::TOTAL_BITS'(r_row_sum[1])
                         + c3er_pkg::TOTAL_BITS'(r_row_sum[2]);
            r_out_pixel <= w_pix;
            r_s3_eof    <= i_eof;
            r_s4_eof    <= r_s3_eof;
            r_s5_eof    <= r_s4_eof;
            r_out_eof   <= r_s5_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_s3_valid  <= i_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

endmodule

// File: hdl/conv3x3_edge_replicate_core.sv
// top level of the 3x3 replicate-border convolution core
//
//  channel   direction  handshake                 payload
//  in        to core    i_in_valid / o_in_stall   i_op, i_pixel_in
//  out       from core  o_out_valid / i_out_stall o_pixel_out, o_end_of_frame
//  cfg       to core    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word per clock sustained in both directions unless the queue fills or the output
// stalls; a result passes the queue, the line-store read and the multiply/add pipe
// the front end takes words into a four-deep queue; the back end stalls as a whole
// only while the output register holds an untaken pixel, so input keeps flowing
// until the queue fills
// reset is synchronous and active low; the line stores are not cleared and need no
// clearing pass, since a frame writes each column before reading it
// cfg is always ready; width or height writes restart the frame
`timescale 1ns / 1ps
module conv3x3_edge_replicate_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [c3er_pkg::PIX_BITS-1:0]       i_pixel_in,
    // filtered words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [c3er_pkg::PIX_BITS-1:0]       o_pixel_out,
    output logic                                o_end_of_frame,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [c3er_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [c3er_pkg::COEF_REG_BITS-1:0]  i_cfg_data
);

    // configuration registers
    logic [c3er_pkg::DIM_BITS-1:0]      r_frame_width;
    logic [c3er_pkg::DIM_BITS-1:0]      r_frame_height;
    logic [c3er_pkg::COEF_REG_BITS-1:0] r_coef_top;
    logic [c3er_pkg::COEF_REG_BITS-1:0] r_coef_middle;
    logic [c3er_pkg::COEF_REG_BITS-1:0] r_coef_bottom;

    logic                               w_cfg_wr;
    logic                               w_geom_clear;
    logic [c3er_pkg::DIM_BITS-1:0]      w_width;
    logic [c3er_pkg::DIM_BITS-1:0]      w_height;
    c3er_pkg::t_coef_rows               w_coef;

    // front end to queue
    logic                               w_push;
    c3er_pkg::t_cmd                     w_cmd;
    c3er_pkg::t_cmd                     w_head;
    logic                               w_q_empty;
    logic                               w_q_full;
    logic [c3er_pkg::QCNT_BITS-1:0]     w_q_count;

    // back end
    logic                               w_adv;
    logic                               w_pop;
    logic                               w_win_valid;
    c3er_pkg::t_win                     w_win_pix;
    logic                               w_win_eof;

    always_comb begin
        o_cfg_ready  = 1'b1;
        w_cfg_wr     = i_cfg_valid && o_cfg_ready;
        w_geom_clear = w_cfg_wr && ((i_cfg_index == c3er_pkg::REG_FRAME_WIDTH)
                                 || (i_cfg_index == c3er_pkg::REG_FRAME_HEIGHT));
        w_width      = c3er_pkg::eff_dim(r_frame_width,
                                         c3er_pkg::DIM_BITS'(c3er_pkg::MAX_WIDTH));
        w_height     = c3er_pkg::eff_dim(r_frame_height,
                                         c3er_pkg::DIM_BITS'(c3er_pkg::MAX_HEIGHT));
        w_coef[0]    = r_coef_top;
        w_coef[1]    = r_coef_middle;
        w_coef[2]    = r_coef_bottom;
        // the whole back end moves unless a finished pixel is held up
        w_adv        = !(o_out_valid && i_out_stall);
        w_pop        = w_adv && !w_q_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= c3er_pkg::FRAME_WIDTH_RST;
            r_frame_height <= c3er_pkg::FRAME_HEIGHT_RST;
            r_coef_top     <= c3er_pkg::COEF_EDGE_RST;
            r_coef_middle  <= c3er_pkg::COEF_MIDDLE_RST;
            r_coef_bottom  <= c3er_pkg::COEF_EDGE_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                c3er_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[c3er_pkg::DIM_BITS-1:0];
                end
                c3er_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[c3er_pkg::DIM_BITS-1:0];
                end
                c3er_pkg::REG_COEF_TOP: begin
                    r_coef_top <= i_cfg_data;
                end
                c3er_pkg::REG_COEF_MIDDLE: begin
                    r_coef_middle <= i_cfg_data;
                end
                c3er_pkg::REG_COEF_BOTTOM: begin
                    r_coef_bottom <= i_cfg_data;
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    c3er_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_geom_clear),
        .i_width    (w_width),
        .i_height   (w_height),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_pixel_in (i_pixel_in),
        .i_full     (w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    c3er_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_count (w_q_count)
    );

    c3er_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_clear     (w_geom_clear),
        .i_cmd_valid (!w_q_empty),
        .i_cmd       (w_head),
        .o_valid     (w_win_valid),
        .o_pix       (w_win_pix),
        .o_eof       (w_win_eof)
    );

    c3er_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (w_win_valid),
        .i_pix       (w_win_pix),
        .i_eof       (w_win_eof),
        .i_coef      (w_coef),
        .o_valid     (o_out_valid),
        .o_pixel_out (o_pixel_out),
        .o_eof       (o_end_of_frame)
    );

    // a held output freezes the back end, so the queue cannot drain meanwhile
    a_freeze_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (w_q_count >= $past(w_q_count)))
        else $error("queue drained while output held");

endmodule
